/* src/pcc_pkg.sv */
package pcc_pkg;

  // light sequence phases
  typedef enum logic [2:0] {
    PH_GREEN     = 3'd0,
    PH_YELLOW    = 3'd1,
    PH_RED       = 3'd2,
    PH_WALK      = 3'd3,
    PH_PRE_GREEN = 3'd4
  } phase_t;

  // lamp pattern of one phase
  typedef struct packed {
    logic car_red;
    logic veh_yellow;
    logic veh_green;
    logic walk_green;
    logic walk_red;
  } lamps_t;

  // register indexes on the config port (byte address = 4 * index)
  localparam int CfgAddrW = 5;
  localparam logic [2:0] REG_DETECT    = 3'd0;
  localparam logic [2:0] REG_RELEASE   = 3'd1;
  localparam logic [2:0] REG_GREEN     = 3'd2;
  localparam logic [2:0] REG_YELLOW    = 3'd3;
  localparam logic [2:0] REG_RED       = 3'd4;
  localparam logic [2:0] REG_CROSS     = 3'd5;
  localparam logic [2:0] REG_PRE_GREEN = 3'd6;

  // register reset values
  localparam logic [9:0]  DETECT_RST    = 10'd20;
  localparam logic [9:0]  RELEASE_RST   = 10'd30;
  localparam logic [15:0] GREEN_RST     = 16'd5000;
  localparam logic [15:0] YELLOW_RST    = 16'd2000;
  localparam logic [15:0] RED_RST       = 16'd1000;
  localparam logic [15:0] CROSS_RST     = 16'd4000;
  localparam logic [15:0] PRE_GREEN_RST = 16'd2000;

  // distance = floor(ticks * 17 / 2000) as (ticks * RecipM) >> RecipShift,
  // exact for every 16-bit tick count
  localparam int          RecipShift = 27;
  localparam logic [20:0] RecipM     = 21'd1140851;
  localparam logic [9:0]  NoObjectCm = 10'd999;

endpackage

/* src/pcc_if.sv */
// input channel: one control round per word
interface pcc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [15:0] pulse_a;
  logic [15:0] pulse_b;
  logic [15:0] pulse_c;
  logic        valid_a;
  logic        valid_b;
  logic        valid_c;

  modport source (output valid, now_ms, pulse_a, pulse_b, pulse_c,
                  valid_a, valid_b, valid_c, input ready);
  modport sink   (input valid, now_ms, pulse_a, pulse_b, pulse_c,
                  valid_a, valid_b, valid_c, output ready);
endinterface

// result channel: lamps, new phase, median distance and presence flag
interface pcc_out_if;
  logic       valid;
  logic       ready;
  logic       car_red;
  logic       veh_yellow;
  logic       veh_green;
  logic       walk_green;
  logic       walk_red;
  logic [2:0] next_phase;
  logic [9:0] median_cm;
  logic       pedestrian;

  modport source (output valid, car_red, veh_yellow, veh_green, walk_green,
                  walk_red, next_phase, median_cm, pedestrian, input ready);
  modport sink   (input valid, car_red, veh_yellow, veh_green, walk_green,
                  walk_red, next_phase, median_cm, pedestrian, output ready);
endinterface

/* src/pedestrian_crossing_controller.sv */
// Pedestrian crossing controller.
// in_ch takes one control round per word: the millisecond time and three
// ultrasonic echo widths with their valid flags. out_ch returns one word per
// round: the lamp pattern of the phase held when the round began, the phase
// after the round, the median distance in cm (999 = no object) and the
// pedestrian presence flag.
// Path: a word accepted from in_ch is held in the input register; its
// result is loaded into the output register once that register is free,
// and then shows on out_ch. Throughput is one word per cycle while out_ch
// is ready, set by the single pass from input register to output register
// that also updates phase, phase start time and presence.
// Stall: while out_ch is not ready the output register holds; the input
// register still takes one more word, then in_ch.ready drops until the
// output side drains.
// Reset (rst_n low at a clock edge): both channels empty, phase green,
// phase start 0, no pedestrian, all thresholds and durations at defaults.
// Config: APB-style, registers at byte address 4*i, write only while idle.
module pedestrian_crossing_controller
  import pcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  pcc_in_if.sink              in_ch,
  pcc_out_if.source           out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // config registers
  logic [9:0]  detect_cm_r, release_cm_r;
  logic [15:0] green_ms_r, yellow_ms_r, red_ms_r, cross_ms_r, pre_green_ms_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // input register
  logic        s1_valid_r;
  logic [31:0] s1_now_r;
  logic [15:0] s1_pulse_a_r, s1_pulse_b_r, s1_pulse_c_r;
  logic        s1_ok_a_r, s1_ok_b_r, s1_ok_c_r;

  // block state
  phase_t      phase_r, phase_nxt;
  logic [31:0] phase_start_r, phase_start_nxt;
  logic        presence_r, presence_nxt;

  // output register
  logic        out_valid_r;
  lamps_t      out_lamps_r, lamps;
  logic [2:0]  out_phase_r;
  logic [9:0]  out_median_r;
  logic        out_ped_r;

  logic        advance;
  logic [9:0]  dist_a, dist_b, dist_c, median;
  logic [31:0] elapsed;

  // echo width to cm via reciprocal multiply
  function automatic logic [9:0] echo_cm(input logic [15:0] ticks, input logic ok);
    logic [36:0] prod;
    prod = 37'(ticks) * 37'(RecipM);
    return ok ? prod[RecipShift+9:RecipShift] : NoObjectCm;
  endfunction

  // median of three by a three-compare sort
  function automatic logic [9:0] median3(input logic [9:0] a0, input logic [9:0] b0,
                                         input logic [9:0] c0);
    logic [9:0] a, b, c, t;
    a = a0; b = b0; c = c0;
    if (a > b) begin t = a; a = b; b = t; end
    if (b > c) begin t = b; b = c; c = t; end
    if (a > b) begin t = a; a = b; b = t; end
    return b;
  endfunction

  // ---------------- config port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[CfgAddrW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detect_cm_r    <= DETECT_RST;
      release_cm_r   <= RELEASE_RST;
      green_ms_r     <= GREEN_RST;
      yellow_ms_r    <= YELLOW_RST;
      red_ms_r       <= RED_RST;
      cross_ms_r     <= CROSS_RST;
      pre_green_ms_r <= PRE_GREEN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DETECT:    detect_cm_r    <= pwdata[9:0];
        REG_RELEASE:   release_cm_r   <= pwdata[9:0];
        REG_GREEN:     green_ms_r     <= pwdata[15:0];
        REG_YELLOW:    yellow_ms_r    <= pwdata[15:0];
        REG_RED:       red_ms_r       <= pwdata[15:0];
        REG_CROSS:     cross_ms_r     <= pwdata[15:0];
        REG_PRE_GREEN: pre_green_ms_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_DETECT:    prdata = 32'(detect_cm_r);
      REG_RELEASE:   prdata = 32'(release_cm_r);
      REG_GREEN:     prdata = 32'(green_ms_r);
      REG_YELLOW:    prdata = 32'(yellow_ms_r);
      REG_RED:       prdata = 32'(red_ms_r);
      REG_CROSS:     prdata = 32'(cross_ms_r);
      REG_PRE_GREEN: prdata = 32'(pre_green_ms_r);
      default:       prdata = 32'd0;
    endcase
  end

  // ---------------- handshake ----------------
  // a word moves from input to output register when the output is free
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_now_r     <= in_ch.now_ms;
      s1_pulse_a_r <= in_ch.pulse_a;
      s1_pulse_b_r <= in_ch.pulse_b;
      s1_pulse_c_r <= in_ch.pulse_c;
      s1_ok_a_r    <= in_ch.valid_a;
      s1_ok_b_r    <= in_ch.valid_b;
      s1_ok_c_r    <= in_ch.valid_c;
    end
  end

  // ---------------- distance and presence ----------------
  assign dist_a = echo_cm(s1_pulse_a_r, s1_ok_a_r);
  assign dist_b = echo_cm(s1_pulse_b_r, s1_ok_b_r);
  assign dist_c = echo_cm(s1_pulse_c_r, s1_ok_c_r);
  assign median = median3(dist_a, dist_b, dist_c);

  // set test first, so it wins when thresholds cross
  always_comb begin
    presence_nxt = presence_r;
    if (median != NoObjectCm && median < detect_cm_r) begin
      presence_nxt = 1'b1;
    end else if (median == NoObjectCm || median > release_cm_r) begin
      presence_nxt = 1'b0;
    end
  end

  // ---------------- phase sequencer ----------------
  assign elapsed = s1_now_r - phase_start_r;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_GREEN: begin
        if (presence_nxt && elapsed >= 32'(green_ms_r)) phase_nxt = PH_YELLOW;
      end
      PH_YELLOW: begin
        if (elapsed >= 32'(yellow_ms_r)) phase_nxt = PH_RED;
      end
      PH_RED: begin
        if (presence_nxt) phase_nxt = PH_WALK;
        else if (elapsed >= 32'(red_ms_r)) phase_nxt = PH_PRE_GREEN;
      end
      PH_WALK: begin
        if (elapsed >= 32'(cross_ms_r)) phase_nxt = PH_PRE_GREEN;
      end
      PH_PRE_GREEN: begin
        if (elapsed >= 32'(pre_green_ms_r)) phase_nxt = PH_GREEN;
      end
      default: phase_nxt = PH_GREEN;
    endcase
  end

  // unknown codes always restart timing, like any transition
  always_comb begin
    phase_start_nxt = phase_start_r;
    if (phase_nxt != phase_r || phase_r > PH_PRE_GREEN) phase_start_nxt = s1_now_r;
  end

  // outputs: lamps of the current phase
  always_comb begin
    case (phase_r)
      PH_GREEN:     lamps = '{car_red: 1'b0, veh_yellow: 1'b0, veh_green: 1'b1,
                              walk_green: 1'b0, walk_red: 1'b1};
      PH_YELLOW:    lamps = '{car_red: 1'b0, veh_yellow: 1'b1, veh_green: 1'b0,
                              walk_green: 1'b0, walk_red: 1'b1};
      PH_RED:       lamps = '{car_red: 1'b1, veh_yellow: 1'b0, veh_green: 1'b0,
                              walk_green: 1'b0, walk_red: 1'b1};
      PH_WALK:      lamps = '{car_red: 1'b1, veh_yellow: 1'b0, veh_green: 1'b0,
                              walk_green: 1'b1, walk_red: 1'b0};
      PH_PRE_GREEN: lamps = '{car_red: 1'b1, veh_yellow: 1'b1, veh_green: 1'b0,
                              walk_green: 1'b0, walk_red: 1'b1};
      default:      lamps = '{car_red: 1'b0, veh_yellow: 1'b0, veh_green: 1'b1,
                              walk_green: 1'b0, walk_red: 1'b1};
    endcase
  end

  // state update on each word that moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_GREEN;
      phase_start_r <= 32'd0;
      presence_r    <= 1'b0;
    end else if (advance) begin
      phase_r       <= phase_nxt;
      phase_start_r <= phase_start_nxt;
      presence_r    <= presence_nxt;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_lamps_r  <= lamps;
      out_phase_r  <= phase_nxt;
      out_median_r <= median;
      out_ped_r    <= presence_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.car_red    = out_lamps_r.car_red;
  assign out_ch.veh_yellow = out_lamps_r.veh_yellow;
  assign out_ch.veh_green  = out_lamps_r.veh_green;
  assign out_ch.walk_green = out_lamps_r.walk_green;
  assign out_ch.walk_red   = out_lamps_r.walk_red;
  assign out_ch.next_phase = out_phase_r;
  assign out_ch.median_cm  = out_median_r;
  assign out_ch.pedestrian = out_ped_r;

  // ---------------- assertions ----------------
  // a waiting result reflects the state it left behind
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_phase_r == phase_r && out_ped_r == presence_r))
    else $error("output word does not match held phase/presence");

  // every phase change restarts the phase timer at the round's time
  a_start_on_change: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && phase_r != $past(phase_r)) |-> phase_start_r == $past(s1_now_r))
    else $error("phase start not loaded on phase change");

  // yellow only ever leads to red
  a_yellow_to_red: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(phase_r) == PH_YELLOW && phase_r != PH_YELLOW)
      |-> phase_r == PH_RED)
    else $error("illegal exit from yellow");

endmodule
